/* rtl/rswa_pkg.sv */
// Shared types, constants and the sine table for the radial sine warp addresser.
// Depends on nothing; every other file imports it.
package rswa_pkg;

	// Field widths and geometry.
	localparam int COORD_W     = 12;
	localparam int RING_W      = 9;
	localparam int SIZE_W      = 13;
	localparam int AMP_W       = 16;
	localparam int STEP_W      = 13;
	localparam int PHASE_W     = RING_W + STEP_W;
	localparam int SAMPLE_W    = 16;
	localparam int PROD_W      = SAMPLE_W + AMP_W;
	localparam int SUM_W       = COORD_W + 6;
	localparam int FRAC_SHIFT  = 15;
	localparam int MAX_DIM     = 4096;

	// Table geometry: a full sine period plus a quarter period for cosine reads.
	localparam int SINE_ENTRIES = 1024;
	localparam int ROM_DEPTH    = SINE_ENTRIES + SINE_ENTRIES / 4;
	localparam int ROM_AW       = $clog2(ROM_DEPTH);
	localparam int IDX_W        = $clog2(SINE_ENTRIES);
	localparam int COS_OFFSET   = SINE_ENTRIES / 4;
	localparam int HALF_PERIOD  = SINE_ENTRIES / 2;
	localparam int QUARTER      = SINE_ENTRIES / 4;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_AMPLITUDE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_AMPLITUDE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd4;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

	// One input beat and one result beat.
	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [RING_W-1:0]  ring;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] source_x;
		logic [COORD_W-1:0] source_y;
	} result_t;

	typedef logic [ROM_DEPTH-1:0][SAMPLE_W-1:0] rom_t;

	localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
	localparam logic [63:0] LOW32  = 64'h00000000FFFFFFFF;

	// Largest legal coordinate for an image size; zero acts as one and
	// anything above the maximum dimension acts as the maximum.
	function automatic logic [COORD_W-1:0] size_to_limit(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] eff;
		begin
			if (size == '0) begin
				eff = SIZE_W'(1);
			end else if (size > SIZE_W'(MAX_DIM)) begin
				eff = SIZE_W'(MAX_DIM);
			end else begin
				eff = size;
			end
			size_to_limit = COORD_W'(eff - SIZE_W'(1));
		end
	endfunction

	// (a * b) >> 61 for unsigned Q61 operands, built from 32-bit partial products.
	function automatic logic [63:0] q61_mul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ah, al, bh, bl, ll, lh, hl, hh, mid, lo, hi;
		begin
			ah  = a >> 32;
			al  = a & LOW32;
			bh  = b >> 32;
			bl  = b & LOW32;
			ll  = al * bl;
			lh  = al * bh;
			hl  = ah * bl;
			hh  = ah * bh;
			mid = (ll >> 32) + (lh & LOW32) + (hl & LOW32);
			lo  = (ll & LOW32) | (mid << 32);
			hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
			q61_mul = (hi << 3) | (lo >> 61);
		end
	endfunction

	// Truncated 32767 * sin(q * pi / 512) for q in 0..256, by a Taylor series.
	function automatic logic [SAMPLE_W-1:0] quarter_sine(input logic [63:0] q);
		logic [63:0] x, x2, term, sum, t;
		begin
			x    = q61_mul(PI_Q61, q << 52);
			x2   = q61_mul(x, x);
			term = x;
			sum  = x;
			term = q61_mul(term, x2) / 64'd6;   sum = sum - term;
			term = q61_mul(term, x2) / 64'd20;  sum = sum + term;
			term = q61_mul(term, x2) / 64'd42;  sum = sum - term;
			term = q61_mul(term, x2) / 64'd72;  sum = sum + term;
			term = q61_mul(term, x2) / 64'd110; sum = sum - term;
			term = q61_mul(term, x2) / 64'd156; sum = sum + term;
			term = q61_mul(term, x2) / 64'd210; sum = sum - term;
			term = q61_mul(term, x2) / 64'd272; sum = sum + term;
			term = q61_mul(term, x2) / 64'd342; sum = sum - term;
			term = q61_mul(term, x2) / 64'd420; sum = sum + term;
			term = q61_mul(term, x2) / 64'd506; sum = sum - term;
			term = q61_mul(term, x2) / 64'd600; sum = sum + term;
			term = q61_mul(term, x2) / 64'd702; sum = sum - term;
			term = q61_mul(term, x2) / 64'd812; sum = sum + term;
			t = (sum >> 32) * 64'd32767 + (((sum & LOW32) * 64'd32767) >> 32);
			quarter_sine = SAMPLE_W'((t + 64'd1) >> 29);
		end
	endfunction

	// Full table: one sine period from quarter-wave symmetry, then the first
	// quarter repeated so that a cosine read never wraps.
	function automatic rom_t build_rom();
		logic [SAMPLE_W-1:0] quarter [QUARTER+1];
		logic [SAMPLE_W-1:0] v;
		rom_t rom;
		int q;
		begin
			for (int j = 0; j <= QUARTER; j++) begin
				quarter[j] = quarter_sine(64'(j));
			end
			for (int k = 0; k < SINE_ENTRIES; k++) begin
				q = k % HALF_PERIOD;
				v = (q <= QUARTER) ? quarter[q] : quarter[HALF_PERIOD - q];
				rom[k] = (k >= HALF_PERIOD) ? SAMPLE_W'(-v) : v;
			end
			for (int k = 0; k < COS_OFFSET; k++) begin
				rom[SINE_ENTRIES + k] = rom[k];
			end
			build_rom = rom;
		end
	endfunction

	localparam rom_t SINE_ROM = build_rom();

endpackage

/* rtl/rswa_sine_rom.sv */
// Sine table memory with two synchronous read ports.
// Depends on rswa_pkg for the table contents and widths.
module rswa_sine_rom (
	input  logic                         clk,
	input  logic [rswa_pkg::ROM_AW-1:0]  sin_addr,
	input  logic [rswa_pkg::ROM_AW-1:0]  cos_addr,
	output logic [rswa_pkg::SAMPLE_W-1:0] sine,
	output logic [rswa_pkg::SAMPLE_W-1:0] cosine
);
	import rswa_pkg::*;

	logic [SAMPLE_W-1:0] sine_q;
	logic [SAMPLE_W-1:0] cosine_q;

	// Registered reads from the constant table.
	always_ff @(posedge clk) begin
		sine_q   <= SINE_ROM[sin_addr];
		cosine_q <= SINE_ROM[cos_addr];
	end

	assign sine   = sine_q;
	assign cosine = cosine_q;

endmodule

/* rtl/rswa_displace_lane.sv */
// One axis of the warp: gain product, floor shift, offset and clamp to the image.
// Depends on rswa_pkg for widths; two stages, the last one drives the coordinate.
module rswa_displace_lane (
	input  logic                          clk,
	input  logic [rswa_pkg::SAMPLE_W-1:0] sample,
	input  logic [rswa_pkg::AMP_W-1:0]    amplitude,
	input  logic [rswa_pkg::COORD_W-1:0]  coord,
	input  logic [rswa_pkg::COORD_W-1:0]  limit,
	output logic [rswa_pkg::COORD_W-1:0]  source
);
	import rswa_pkg::*;

	logic signed [PROD_W-1:0] prod_s3;
	logic [COORD_W-1:0]       coord_s3;
	logic [COORD_W-1:0]       source_s4;
	logic signed [PROD_W-1:0] shifted;
	logic signed [SUM_W-1:0]  moved;

	// Signed product of table sample and gain.
	always_ff @(posedge clk) begin
		prod_s3  <= $signed(sample) * $signed(amplitude);
		coord_s3 <= coord;
	end

	// Arithmetic shift rounds toward minus infinity; the result fits in the sum, which is
	// six bits wider than the coordinate.
	always_comb begin
		shifted = prod_s3 >>> FRAC_SHIFT;
		moved   = SUM_W'(shifted) + $signed({{(SUM_W-COORD_W){1'b0}}, coord_s3});
	end

	// Clamp to zero and to the last row or column.
	always_ff @(posedge clk) begin
		if (moved[SUM_W-1]) begin
			source_s4 <= '0;
		end else if (moved[SUM_W-2:0] > {{(SUM_W-1-COORD_W){1'b0}}, limit}) begin
			source_s4 <= limit;
		end else begin
			source_s4 <= moved[COORD_W-1:0];
		end
	end

	assign source = source_s4;

endmodule

/* rtl/radial_sine_warp_addresser_unit.sv */
// Top level of the radial sine warp addresser: configuration registers, phase
// and table addressing, two displacement lanes. Depends on rswa_pkg,
// rswa_sine_rom and rswa_displace_lane.
//
// The block maps each destination pixel to a clamped source coordinate and takes
// one pixel every clock: busy is always low. A result appears on result with done
// high for exactly one cycle once its start beat has passed the registered stages
// (phase and address, registered table read, gain multiply, clamp), in the order of the start beats;
// the receiver has no way to stall it and must take every done beat. cfg_ready is
// always high. Write configuration only while no pixel is in flight.
module radial_sine_warp_addresser_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  rswa_pkg::item_t                 item,
	output logic                            done,
	output rswa_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rswa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rswa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rswa_pkg::*;

	logic [SIZE_W-1:0] image_width_q;
	logic [SIZE_W-1:0] image_height_q;
	logic [AMP_W-1:0]  x_amplitude_q;
	logic [AMP_W-1:0]  y_amplitude_q;
	logic [STEP_W-1:0] phase_step_q;

	logic               accept;
	logic [PHASE_W-1:0] phase;
	logic [IDX_W-1:0]   idx_s1;
	logic [ROM_AW-1:0]  sin_addr;
	logic [ROM_AW-1:0]  cos_addr;
	logic [COORD_W-1:0] px_s1, py_s1, px_s2, py_s2;
	logic               v_s1, v_s2, v_s3, done_q;
	logic [SAMPLE_W-1:0] sine, cosine;
	logic [COORD_W-1:0] lim_x, lim_y;
	logic [COORD_W-1:0] source_x, source_y;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
			x_amplitude_q  <= '0;
			y_amplitude_q  <= '0;
			phase_step_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[SIZE_W-1:0];
				REG_X_AMPLITUDE:  x_amplitude_q  <= cfg_data[AMP_W-1:0];
				REG_Y_AMPLITUDE:  y_amplitude_q  <= cfg_data[AMP_W-1:0];
				REG_PHASE_STEP:   phase_step_q   <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign lim_x = size_to_limit(image_width_q);
	assign lim_y = size_to_limit(image_height_q);

	// Ring phase; bits 12:4 pick an even table entry.
	assign phase = PHASE_W'(item.ring) * PHASE_W'(phase_step_q);

	always_ff @(posedge clk) begin
		idx_s1 <= {phase[12:4], 1'b0};
		px_s1  <= item.pixel_x;
		py_s1  <= item.pixel_y;
		px_s2  <= px_s1;
		py_s2  <= py_s1;
	end

	// Valid bits that follow each beat down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	// Sine at the index, cosine a quarter period further on.
	assign sin_addr = ROM_AW'(idx_s1);
	assign cos_addr = ROM_AW'(idx_s1) + ROM_AW'(COS_OFFSET);

	rswa_sine_rom u_rom (
		.clk      (clk),
		.sin_addr (sin_addr),
		.cos_addr (cos_addr),
		.sine     (sine),
		.cosine   (cosine)
	);

	rswa_displace_lane u_lane_x (
		.clk       (clk),
		.sample    (cosine),
		.amplitude (x_amplitude_q),
		.coord     (px_s2),
		.limit     (lim_x),
		.source    (source_x)
	);

	rswa_displace_lane u_lane_y (
		.clk       (clk),
		.sample    (sine),
		.amplitude (y_amplitude_q),
		.coord     (py_s2),
		.limit     (lim_y),
		.source    (source_y)
	);

	assign done            = done_q;
	assign result.source_x = source_x;
	assign result.source_y = source_y;

	// Every accepted beat yields a done beat through v_s1, v_s2, v_s3 and done_q, and no other.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("start beat without done four cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("done without a start beat four cycles before");

	// Delivered coordinates stay inside the image.
	a_x_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.source_x <= lim_x))
		else $error("source_x beyond image width");

	a_y_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.source_y <= lim_y))
		else $error("source_y beyond image height");

endmodule
